// ===== sv/tcd_pkg.sv =====
// Package for the two-color tile decoder.
// Holds the shared types, register codes and constants; no dependencies.
package tcd_pkg;

  // Input item opcodes
  typedef enum logic {
    OP_PALETTE = 1'b0,
    OP_TILE    = 1'b1
  } op_e;

  // Configuration register indexes
  typedef enum logic {
    CFG_TILES_ACROSS = 1'b0,
    CFG_TILES_DOWN   = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgW          = 9;
  localparam logic [CfgW-1:0] AcrossRst = 9'd160;
  localparam logic [CfgW-1:0] DownRst   = 9'd120;

  // Depth of the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Tile count registers as seen by the back end
  typedef struct packed {
    logic [CfgW-1:0] tiles_across;
    logic [CfgW-1:0] tiles_down;
  } cfg_t;

  // One classified tile with its colors resolved
  typedef struct packed {
    logic [23:0] rgb_set;
    logic [23:0] rgb_clear;
    logic [15:0] mask_bits;
  } tile_t;

endpackage

// ===== sv/tcd_in_if.sv =====
// Input channel of the two-color tile decoder: valid/ready plus item fields.
// Depends on nothing.
interface tcd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] palette_slot;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] color_set;
  logic [7:0] color_clear;
  logic [15:0] mask_bits;

  modport source (output valid, op, palette_slot, red_in, green_in, blue_in,
                  color_set, color_clear, mask_bits, input ready);
  modport sink (input valid, op, palette_slot, red_in, green_in, blue_in,
                color_set, color_clear, mask_bits, output ready);
endinterface

// ===== sv/tcd_out_if.sv =====
// Output channel of the two-color tile decoder: valid/ready plus pixel fields.
// Depends on nothing.
interface tcd_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] pixel_x;
  logic [9:0] pixel_y;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_of_tile;
  logic       last_of_image;

  modport source (output valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                  last_of_tile, last_of_image, input ready);
  modport sink (input valid, pixel_x, pixel_y, red_out, green_out, blue_out,
                last_of_tile, last_of_image, output ready);
endinterface

// ===== sv/two_color_tile_decoder_unit.sv =====
// Two-color 4x4 tile decoder: palette writes and tile decode, 16 pixels/tile.
// A tile's first pixel passes the front lookup, queue and back-end tile
// and pixel registers before it is offered. Throughput: one pixel per cycle
// unless the output stalls, set by the pixel walk; palette writes give no pixel.
// Reset: tile position zero, tiles_across 160, tiles_down 120; palette uncleared.
module two_color_tile_decoder_unit #(
  parameter int unsigned PALETTE_ENTRIES    = 256,
  parameter int unsigned MAX_TILES_PER_SIDE = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  tcd_in_if.sink                   in_i,
  tcd_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [tcd_pkg::CfgW-1:0] cfg_data_i
);

  tcd_pkg::cfg_t  cfg_q;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  tcd_pkg::tile_t push_tile, pop_tile;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tiles_across <= tcd_pkg::AcrossRst;
      cfg_q.tiles_down   <= tcd_pkg::DownRst;
    end else if (cfg_we_i) begin
      unique case (tcd_pkg::cfg_idx_e'(cfg_idx_i))
        tcd_pkg::CFG_TILES_ACROSS: cfg_q.tiles_across <= cfg_data_i;
        tcd_pkg::CFG_TILES_DOWN:   cfg_q.tiles_down   <= cfg_data_i;
      endcase
    end
  end

  tcd_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_tile_o (push_tile)
  );

  tcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_tile_i (push_tile),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_tile_o  (pop_tile)
  );

  tcd_back #(
    .MAX_TILES_PER_SIDE(MAX_TILES_PER_SIDE)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_tile_i (pop_tile),
    .out_o      (out_o)
  );

endmodule

// ===== sv/tcd_front.sv =====
// Front end: accepts requests, writes the palette, looks up tile colors.
// Depends on tcd_pkg and tcd_in_if.
module tcd_front #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcd_in_if.sink        in_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output tcd_pkg::tile_t push_tile_o
);

  localparam int unsigned IdxW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0] palette_mem [PALETTE_ENTRIES];

  logic        accept, accept_tile, accept_pal, push;
  logic        slot_ok, set_ok, clr_ok;
  logic        s1_valid_q, s1_valid_d;
  logic        s1_set_ok_q, s1_clr_ok_q;
  logic [15:0] s1_mask_q;
  logic [23:0] rd_set_q, rd_clr_q;

  // Classify the request
  assign accept      = in_i.valid && in_i.ready;
  assign accept_tile = accept && (in_i.op == tcd_pkg::OP_TILE);
  assign accept_pal  = accept && (in_i.op == tcd_pkg::OP_PALETTE);
  assign push        = s1_valid_q && push_ready_i;
  assign in_i.ready  = !s1_valid_q || push_ready_i;

  // Check slots against the palette size
  assign slot_ok = {1'b0, in_i.palette_slot} < 9'(PALETTE_ENTRIES);
  assign set_ok  = {1'b0, in_i.color_set} < 9'(PALETTE_ENTRIES);
  assign clr_ok  = {1'b0, in_i.color_clear} < 9'(PALETTE_ENTRIES);

  // Write and read the palette memory
  always_ff @(posedge clk_i) begin
    if (accept_pal && slot_ok) begin
      palette_mem[in_i.palette_slot[IdxW-1:0]] <= {in_i.red_in, in_i.green_in, in_i.blue_in};
    end
    if (accept_tile) begin
      rd_set_q    <= palette_mem[in_i.color_set[IdxW-1:0]];
      rd_clr_q    <= palette_mem[in_i.color_clear[IdxW-1:0]];
      s1_set_ok_q <= set_ok;
      s1_clr_ok_q <= clr_ok;
      s1_mask_q   <= in_i.mask_bits;
    end
  end

  // Hold the looked-up tile until the queue takes it
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_tile) begin
      s1_valid_d = 1'b1;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Drop colors of slots beyond the palette
  assign push_valid_o           = s1_valid_q;
  assign push_tile_o.rgb_set    = s1_set_ok_q ? rd_set_q : 24'd0;
  assign push_tile_o.rgb_clear  = s1_clr_ok_q ? rd_clr_q : 24'd0;
  assign push_tile_o.mask_bits  = s1_mask_q;

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !push_ready_i) |=> s1_valid_q)
    else $error("front dropped a tile while the queue was full");

endmodule

// ===== sv/tcd_queue.sv =====
// Short queue of classified tiles between front and back.
// Depends on tcd_pkg.
module tcd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  tcd_pkg::tile_t push_tile_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output tcd_pkg::tile_t pop_tile_o
);

  localparam int unsigned Depth = tcd_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  tcd_pkg::tile_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_tile_o   = entries_q[rd_ptr_q];

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_tile_i;
    end
  end

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count beyond depth");

endmodule

// ===== sv/tcd_back.sv =====
// Back end: walks each tile's sixteen pixels, tracks the tile position,
// and drives the registered output channel. Depends on tcd_pkg, tcd_out_if.
module tcd_back #(
  parameter int unsigned MAX_TILES_PER_SIDE = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcd_pkg::cfg_t  cfg_i,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  tcd_pkg::tile_t pop_tile_i,
  tcd_out_if.source      out_o
);

  localparam int unsigned PosW = (MAX_TILES_PER_SIDE > 1) ? $clog2(MAX_TILES_PER_SIDE) : 1;

  logic           cur_valid_q, cur_valid_d;
  tcd_pkg::tile_t cur_tile_q;
  logic [3:0]     cnt_q;
  logic [PosW-1:0] col_q, col_d, row_q, row_d;
  logic           out_valid_q, out_valid_d;
  logic [9:0]     px_q, py_q;
  logic [23:0]    rgb_q, rgb_d;
  logic           lot_q, loi_q;
  logic           advance, finish, load;
  logic [10:0]    across_eff, down_eff;
  logic           row_end, image_end;
  logic [9:0]     col_ext, row_ext;

  // Clamp tile counts to one..maximum
  always_comb begin
    across_eff = 11'(cfg_i.tiles_across);
    if (cfg_i.tiles_across == '0) begin
      across_eff = 11'd1;
    end else if (11'(cfg_i.tiles_across) > 11'(MAX_TILES_PER_SIDE)) begin
      across_eff = 11'(MAX_TILES_PER_SIDE);
    end
    down_eff = 11'(cfg_i.tiles_down);
    if (cfg_i.tiles_down == '0) begin
      down_eff = 11'd1;
    end else if (11'(cfg_i.tiles_down) > 11'(MAX_TILES_PER_SIDE)) begin
      down_eff = 11'(MAX_TILES_PER_SIDE);
    end
  end

  assign row_end   = (11'(col_q) + 11'd1) >= across_eff;
  assign image_end = row_end && ((11'(row_q) + 11'd1) >= down_eff);

  // Pixel step control
  assign advance     = cur_valid_q && (!out_valid_q || out_o.ready);
  assign finish      = advance && (cnt_q == 4'd15);
  assign pop_ready_o = !cur_valid_q || finish;
  assign load        = pop_ready_o && pop_valid_i;

  always_comb begin
    cur_valid_d = cur_valid_q;
    if (load) begin
      cur_valid_d = 1'b1;
    end else if (finish) begin
      cur_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Step the tile position after the last pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (finish) begin
      if (row_end) begin
        col_d = '0;
        row_d = image_end ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      col_q       <= col_d;
      row_q       <= row_d;
      if (advance) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // Build the next pixel
  assign col_ext = 10'(col_q);
  assign row_ext = 10'(row_q);
  assign rgb_d   = cur_tile_q.mask_bits[4'd15 - cnt_q] ? cur_tile_q.rgb_set
                                                       : cur_tile_q.rgb_clear;

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_tile_q <= pop_tile_i;
    end
    if (advance) begin
      px_q  <= {col_ext[7:0], cnt_q[1:0]};
      py_q  <= {row_ext[7:0], cnt_q[3:2]};
      rgb_q <= rgb_d;
      lot_q <= cnt_q == 4'd15;
      loi_q <= (cnt_q == 4'd15) && image_end;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_x       = px_q;
  assign out_o.pixel_y       = py_q;
  assign out_o.red_out       = rgb_q[23:16];
  assign out_o.green_out     = rgb_q[15:8];
  assign out_o.blue_out      = rgb_q[7:0];
  assign out_o.last_of_tile  = lot_q;
  assign out_o.last_of_image = loi_q;

  a_image_in_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && loi_q) |-> lot_q)
    else $error("last of image flagged off a tile end");

  a_cnt_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (cnt_q == 4'd0))
    else $error("pixel count did not wrap after tile end");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !advance)
    else $error("stalled pixel overwritten");

endmodule
